// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// The expression must never be true.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: rtl/core/shk_pkg.sv
// ----------------------------------------------------------------------------
// String key hash package
// Types and fixed constants shared by the string hash sequencer and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package shk_pkg;

  // Field widths fixed by the interface.
  localparam int CH_W    = 16;
  localparam int IDX_W   = 24;
  localparam int CNT_W   = 16;
  localparam int DIGIT_W = 16;

  // Weight sequence: starts at 113 and rises by 22 per character.
  localparam int WEIGHT_START = 113;
  localparam int WEIGHT_STEP  = 22;

  // Configuration register indexes and reset values.
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_TABLE_SIZE = 1'b0;
  localparam cfg_index_t REG_MAX_CHARS  = 1'b1;

  localparam logic [IDX_W-1:0] TABLE_SIZE_RESET = 24'd1021;
  localparam logic [CNT_W-1:0] MAX_CHARS_RESET  = 16'd256;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_t;

  // Status reported by a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/string_key_hash_index.sv
// ----------------------------------------------------------------------------
// String key hash index
// Hashes a zero-terminated character stream into a bucket index.
// ----------------------------------------------------------------------------
// Characters enter on the ch channel (ch_valid/ch_stall), one transaction per
// character; a zero character ends the string. Each finished or truncated
// string yields one transaction on the bucket channel with its bucket index.
// Registers are written through the cfg channel (index 0 table_size, index 1
// max_chars); the user must write them only while no string is in flight,
// which the block itself does not enforce. A character runs two products on
// the 16-bit digit multiplier, each over NDIG = ceil(ACC_WIDTH/16) digits,
// then a reduction on the one-bit-per-cycle remainder unit only when the
// running value exceeds a nonzero table size; a character that ends a
// truncated string then goes on to emit its result. A terminator runs a
// reduction, or none with a zero table size; skipped characters are accepted
// without work. ch_stall is high while a character is in work, and a result
// is valid right after the last cycle of the character that causes it.
// The result sits in an output register, so the next character is accepted
// while it waits; a further result waits until that register is taken.
// Reset (rst, synchronous) restores the register defaults, clears the hash
// state and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module string_key_hash_index #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Character channel.
  input  wire logic                        ch_valid,
  output logic                             ch_stall,
  input  wire logic [shk_pkg::CH_W-1:0]    ch,
  // Result channel.
  output logic                             bucket_valid,
  input  wire logic                        bucket_stall,
  output logic      [shk_pkg::IDX_W-1:0]   bucket_index,
  // Configuration channel.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire shk_pkg::cfg_index_t         cfg_index,
  input  wire logic [shk_pkg::IDX_W-1:0]   cfg_data
);

  localparam int W = ACC_WIDTH;

  shk_pkg::state_t state;
  shk_pkg::state_t state_next;

  logic [shk_pkg::IDX_W-1:0] table_size;
  logic [shk_pkg::CNT_W-1:0] max_chars;

  logic [W-1:0]              acc;
  logic [W-1:0]              acc_next;
  logic [W-1:0]              weight;
  logic [W-1:0]              weight_next;
  logic [W-1:0]              weight_inc;
  logic [shk_pkg::CNT_W-1:0] char_count;
  logic [shk_pkg::CNT_W-1:0] char_count_next;
  logic                      skipping_rest;
  logic                      skipping_rest_next;
  logic                      term_pending;
  logic                      term_pending_next;

  logic                      mul_start;
  logic [W-1:0]              mul_a;
  logic [W-1:0]              mul_b;
  logic [W-1:0]              mul_p;
  shk_pkg::unit_stat_t       mul_stat;

  logic                      div_start;
  logic [shk_pkg::IDX_W-1:0] div_rem;
  shk_pkg::unit_stat_t       div_stat;

  logic                      out_load;

  assign weight_inc = weight + W'(shk_pkg::WEIGHT_STEP);
  assign ch_stall   = (state != shk_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;

  // Shared arithmetic units.
  shk_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .stat  (mul_stat)
  );

  shk_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (table_size),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= shk_pkg::TABLE_SIZE_RESET;
      max_chars  <= shk_pkg::MAX_CHARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        shk_pkg::REG_TABLE_SIZE: table_size <= cfg_data;
        shk_pkg::REG_MAX_CHARS:  max_chars  <= cfg_data[shk_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and hash state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= shk_pkg::S_IDLE;
      acc           <= '0;
      weight        <= W'(shk_pkg::WEIGHT_START);
      char_count    <= '0;
      skipping_rest <= 1'b0;
      term_pending  <= 1'b0;
    end else begin
      state         <= state_next;
      acc           <= acc_next;
      weight        <= weight_next;
      char_count    <= char_count_next;
      skipping_rest <= skipping_rest_next;
      term_pending  <= term_pending_next;
    end
  end

  // Next state and unit control.
  always_comb begin
    state_next         = state;
    acc_next           = acc;
    weight_next        = weight;
    char_count_next    = char_count;
    skipping_rest_next = skipping_rest;
    term_pending_next  = term_pending;
    mul_start          = 1'b0;
    mul_a              = weight_inc;
    mul_b              = W'(ch);
    div_start          = 1'b0;
    out_load           = 1'b0;

    case (state)
      shk_pkg::S_IDLE: begin
        if (ch_valid) begin
          if (ch == '0) begin
            if (skipping_rest) begin
              // Terminator of a truncated string: no result.
              skipping_rest_next = 1'b0;
              acc_next           = '0;
              weight_next        = W'(shk_pkg::WEIGHT_START);
              char_count_next    = '0;
            end else if (table_size != '0) begin
              div_start         = 1'b1;
              term_pending_next = 1'b1;
              state_next        = shk_pkg::S_DIV;
            end else begin
              state_next = shk_pkg::S_EMIT;
            end
          end else if (!skipping_rest) begin
            // Start character times the raised weight.
            weight_next = weight_inc;
            mul_start   = 1'b1;
            state_next  = shk_pkg::S_MUL1;
          end
        end
      end

      shk_pkg::S_MUL1: begin
        // Multiply the first product by the weight again.
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = mul_p;
          mul_b      = weight;
          state_next = shk_pkg::S_MUL2;
        end
      end

      shk_pkg::S_MUL2: begin
        if (mul_stat.done) begin
          acc_next        = acc + mul_p;
          char_count_next = char_count + 1'b1;
          state_next      = shk_pkg::S_ADD;
        end
      end

      shk_pkg::S_ADD: begin
        // Reduce only when the value has grown past a nonzero table size.
        if ((acc > W'(table_size)) && (table_size != '0)) begin
          div_start         = 1'b1;
          term_pending_next = 1'b0;
          state_next        = shk_pkg::S_DIV;
        end else begin
          state_next = shk_pkg::S_CHECK;
        end
      end

      shk_pkg::S_DIV: begin
        if (div_stat.done) begin
          acc_next = W'(div_rem);
          if (term_pending) begin
            state_next = shk_pkg::S_EMIT;
          end else begin
            state_next = shk_pkg::S_CHECK;
          end
        end
      end

      shk_pkg::S_CHECK: begin
        // Length limit reached: emit now and skip to the terminator.
        if (char_count >= max_chars) begin
          skipping_rest_next = 1'b1;
          state_next         = shk_pkg::S_EMIT;
        end else begin
          state_next = shk_pkg::S_IDLE;
        end
      end

      shk_pkg::S_EMIT: begin
        if (!bucket_valid || !bucket_stall) begin
          out_load          = 1'b1;
          term_pending_next = 1'b0;
          acc_next          = '0;
          weight_next       = W'(shk_pkg::WEIGHT_START);
          char_count_next   = '0;
          state_next        = shk_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = shk_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_valid <= 1'b0;
    end else if (out_load) begin
      bucket_valid <= 1'b1;
    end else if (!bucket_stall) begin
      bucket_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bucket_index <= acc[shk_pkg::IDX_W-1:0];
    end
  end

  // The multiplier and the remainder unit never run at the same time.
  `ASSERT_NEVER(a_units_exclusive, clk, rst, mul_stat.busy && div_stat.busy)
  // A finished reduction leaves the value below the table size.
  `ASSERT_NEXT(a_rem_below_size, clk, rst, (state == shk_pkg::S_DIV) && div_stat.done, acc < W'(table_size))
  // While skipping a truncated string the character count stays cleared.
  `ASSERT_IMPLIES(a_skip_clear, clk, rst, (state == shk_pkg::S_IDLE) && skipping_rest, char_count == '0)

endmodule

`default_nettype wire

// File: rtl/core/shk_mul.sv
// ----------------------------------------------------------------------------
// Iterative multiplier
// Computes a * b modulo 2^W, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shk_mul #(
  parameter int W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic      [W-1:0]     p,
  output shk_pkg::unit_stat_t   stat
);

  localparam int DW   = shk_pkg::DIGIT_W;
  localparam int NDIG = (W + DW - 1) / DW;
  localparam int BW   = NDIG * DW;
  localparam int CW   = $clog2(NDIG + 1);

  logic [W-1:0]    a_sh;
  logic [BW-1:0]   b_sh;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic [W+DW-1:0] pp;

  // One partial product: the shifted multiplicand times the low digit.
  assign pp = {{DW{1'b0}}, a_sh} * {{W{1'b0}}, b_sh[DW-1:0]};

  // Digit-serial multiply-accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and product registers carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= a;
      b_sh <= BW'(b);
      p    <= '0;
    end else if (busy) begin
      a_sh <= a_sh << DW;
      b_sh <= b_sh >> DW;
      p    <= p + pp[W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/core/shk_div.sv
// ----------------------------------------------------------------------------
// Restoring remainder unit
// Reduces a W-bit dividend modulo a nonzero 24-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shk_div #(
  parameter int W = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [W-1:0]               dividend,
  input  wire logic [shk_pkg::IDX_W-1:0]  divisor,
  output logic      [shk_pkg::IDX_W-1:0]  rem,
  output shk_pkg::unit_stat_t             stat
);

  localparam int RW = shk_pkg::IDX_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q;
  logic [RW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [RW:0]   r_sh;
  logic [RW:0]   diff;

  // Shift in the next dividend bit and trial-subtract the divisor.
  assign r_sh = {rem, q[W-1]};
  assign diff = r_sh - {1'b0, d};

  // Bit counter and handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      d   <= divisor;
      rem <= '0;
    end else if (busy) begin
      q <= q << 1;
      if (r_sh >= {1'b0, d}) begin
        rem <= diff[RW-1:0];
      end else begin
        rem <= r_sh[RW-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: verif/hash_index_checker.sv
// ----------------------------------------------------------------------------
// String key hash index checker
// Watches the character, result and register channels of the hash block.
// It keeps its own copy of the hash state, predicts the bucket index of each
// finished or truncated string, and compares it with each result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_index_checker
  import shk_pkg::*;
#(
  parameter int ACC_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               ch_valid,
  input  wire logic               ch_stall,
  input  wire logic [CH_W-1:0]    ch,
  input  wire logic               bucket_valid,
  input  wire logic               bucket_stall,
  input  wire logic [IDX_W-1:0]   bucket_index,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire cfg_index_t         cfg_index,
  input  wire logic [IDX_W-1:0]   cfg_data,
  output int                      fail_count,
  output int                      pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // Predicted copy of the registers and of the hash state.
  logic [IDX_W-1:0] bucket_total;
  logic [CNT_W-1:0] char_limit;
  logic [ACC_W-1:0] run_val;
  logic [ACC_W-1:0] char_weight;
  logic [CNT_W-1:0] chars_taken;
  logic             skip_rest;

  // Bucket indexes predicted but not yet seen on the result channel.
  logic [IDX_W-1:0] bucket_q[$];

  // Remainder by the table size; a zero size leaves the value unchanged.
  function automatic logic [ACC_W-1:0] fold(input logic [ACC_W-1:0] v);
    if (bucket_total == '0) return v;
    return v % ACC_W'(bucket_total);
  endfunction

  // Advances the hash by one character and reports a bucket index if one is due.
  task automatic hash_char(input logic [CH_W-1:0] c, output bit emit,
                           output logic [IDX_W-1:0] idx);
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] folded;
    emit = 1'b0;
    idx  = '0;
    if (c == '0) begin
      // A terminator after a truncated string only clears the skip state.
      if (!skip_rest) begin
        folded = fold(run_val);
        emit   = 1'b1;
        idx    = folded[IDX_W-1:0];
      end
      skip_rest   = 1'b0;
      run_val     = '0;
      char_weight = ACC_W'(WEIGHT_START);
      chars_taken = '0;
    end else if (!skip_rest) begin
      char_weight = char_weight + ACC_W'(WEIGHT_STEP);
      term        = ACC_W'(c) * char_weight;
      run_val     = run_val + term * char_weight;
      if (run_val > ACC_W'(bucket_total)) run_val = fold(run_val);
      chars_taken = chars_taken + 1'b1;
      // Early result without the final reduction; the rest of the string is dropped.
      if (chars_taken >= char_limit) begin
        emit        = 1'b1;
        idx         = run_val[IDX_W-1:0];
        skip_rest   = 1'b1;
        run_val     = '0;
        char_weight = ACC_W'(WEIGHT_START);
        chars_taken = '0;
      end
    end
  endtask

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin
    bit               emit;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] want;
    if (rst) begin
      bucket_total = TABLE_SIZE_RESET;
      char_limit   = MAX_CHARS_RESET;
      run_val      = '0;
      char_weight  = ACC_W'(WEIGHT_START);
      chars_taken  = '0;
      skip_rest    = 1'b0;
      bucket_q.delete();
    end else begin
      // A result transaction always belongs to an earlier character.
      if (bucket_valid && !bucket_stall) begin
        if (bucket_q.size() == 0) begin
          $error("bucket_index: unexpected transaction, actual %0d", bucket_index);
          fail_count++;
        end else begin
          want = bucket_q.pop_front();
          if (bucket_index !== want) begin
            $error("bucket_index mismatch: expected %0d, actual %0d", want, bucket_index);
            fail_count++;
          end
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_SIZE: bucket_total = cfg_data;
          REG_MAX_CHARS:  char_limit   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // Character transactions.
      if (ch_valid && !ch_stall) begin
        hash_char(ch, emit, idx);
        if (emit) bucket_q.push_back(idx);
      end
    end
    pending_count = bucket_q.size();
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// String key hash index testbench
// Sends directed and random zero-terminated strings through the hash block
// under several register settings, with random gaps on the character side and
// random stalls on the result side. A checker beside the block predicts and
// compares every bucket index; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import shk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_W        = 32;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  // Settle time is taken with margin over the longest character.
  localparam int SETTLE       = 60;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             ch_valid;
  logic             ch_stall;
  logic [CH_W-1:0]  ch;
  logic             bucket_valid;
  logic             bucket_stall;
  logic [IDX_W-1:0] bucket_index;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_index_t       cfg_index;
  logic [IDX_W-1:0] cfg_data;

  int               n_fail;
  int               n_pending;
  int               cycles;
  int               hashed;
  bit               calm;
  logic [CNT_W-1:0] limit_mirror;

  string_key_hash_index #(.ACC_WIDTH(ACC_W)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .ch_valid     (ch_valid),
    .ch_stall     (ch_stall),
    .ch           (ch),
    .bucket_valid (bucket_valid),
    .bucket_stall (bucket_stall),
    .bucket_index (bucket_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  hash_index_checker #(.ACC_W(ACC_W)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .ch_valid      (ch_valid),
    .ch_stall      (ch_stall),
    .ch            (ch),
    .bucket_valid  (bucket_valid),
    .bucket_stall  (bucket_stall),
    .bucket_index  (bucket_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (n_fail),
    .pending_count (n_pending)
  );

  // Clock with a 20 ns period.
  always #10 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The result side stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    bucket_stall <= !calm && ($urandom_range(99) < 21);
  end

  // Presents one character, with an optional gap first, and waits for the
  // transaction. Entered and left at a falling edge.
  task automatic put_char(input logic [CH_W-1:0] c);
    while (!calm && $urandom_range(99) < 21) begin
      ch_valid <= 1'b0;
      @(negedge clk);
    end
    ch_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk); while (ch_stall);
    @(negedge clk);
  endtask

  // Drives one register write and waits for the transaction; valid stays high.
  task automatic write_reg(input cfg_index_t idx, input logic [IDX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_regs(input bit do_size, input logic [IDX_W-1:0] size_word,
                          input bit do_limit, input logic [IDX_W-1:0] limit_word);
    if (do_size) write_reg(REG_TABLE_SIZE, size_word);
    if (do_limit) begin
      write_reg(REG_MAX_CHARS, limit_word);
      limit_mirror = limit_word[CNT_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops the characters, waits for every result, then lets the block settle.
  task automatic wait_quiet();
    ch_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] draw_char();
    case ($urandom_range(3))
      0:       return CH_W'($urandom_range(1, 65535));
      1:       return CH_W'($urandom_range(32, 126));
      2:       return ($urandom_range(1) == 0) ? 16'hFFFF : 16'h8000;
      default: return CH_W'($urandom_range(1, 255));
    endcase
  endfunction

  // Sends a string of len random characters and its terminator. Characters
  // past the length limit are dropped by the block and are not counted.
  task automatic send_random_string(input int len);
    int eff;
    eff = (limit_mirror == '0) ? 1 : int'(limit_mirror);
    for (int k = 1; k <= len; k++) begin
      put_char(draw_char());
      if (k <= eff) hashed++;
    end
    put_char('0);
    hashed++;
  endtask

  initial begin
    logic [IDX_W-1:0] size_word;
    logic [CNT_W-1:0] limit_word;
    logic [7:0]       upper;
    int               n_str;
    int               len;
    int               eff;

    ch_valid     = 1'b0;
    ch           = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_TABLE_SIZE;
    cfg_data     = '0;
    hashed       = 0;
    calm         = 1'b0;
    limit_mirror = MAX_CHARS_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: empty string, short strings, field extremes.
    put_char('0);
    put_char(16'h0041);
    put_char(16'h0042);
    put_char('0);
    put_char(16'hFFFF);
    put_char('0);
    put_char(16'h5555);
    put_char(16'hAAAA);
    put_char('0);

    // Zero table size and zero length limit: early result after one character,
    // the next character is dropped, and an empty string still gives zero.
    wait_quiet();
    set_regs(1'b1, 24'd0, 1'b1, 24'd0);
    put_char(16'hFFFF);
    put_char(16'h1234);
    put_char('0);
    put_char('0);

    // Largest table size, truncation at the third character.
    wait_quiet();
    set_regs(1'b1, 24'hFFFFFF, 1'b1, 24'd3);
    put_char(16'h0001);
    put_char(16'h0002);
    put_char(16'h0003);
    put_char(16'h0004);
    put_char('0);

    // Table size of one and the largest length limit, upper data bits set.
    wait_quiet();
    set_regs(1'b1, 24'd1, 1'b1, 24'hFFFFFF);
    put_char(16'h0078);
    put_char(16'h0079);
    put_char('0);

    // Zero table size at the terminator: the unreduced value is masked.
    wait_quiet();
    set_regs(1'b1, 24'd0, 1'b1, 24'd4);
    put_char(16'hFFFF);
    put_char(16'hFFFF);
    put_char('0);

    // Random phases, each with its own register setting.
    while (hashed < RANDOM_ITEMS) begin
      wait_quiet();
      calm = (hashed >= 600) && (hashed < 1000);
      case ($urandom_range(4))
        0:       size_word = IDX_W'($urandom_range(1, 64));
        1:       size_word = IDX_W'($urandom());
        2:       size_word = ($urandom_range(2) == 0) ? 24'd0 :
                             (($urandom_range(1) == 0) ? 24'hFFFFFF : 24'd1);
        3:       size_word = TABLE_SIZE_RESET;
        default: size_word = IDX_W'($urandom_range(65, 70000));
      endcase
      case ($urandom_range(3))
        0:       limit_word = CNT_W'($urandom_range(1, 8));
        1:       limit_word = CNT_W'($urandom_range(9, 20));
        2:       limit_word = ($urandom_range(2) == 0) ? 16'd0 :
                              (($urandom_range(1) == 0) ? 16'd1 : 16'hFFFF);
        default: limit_word = ($urandom_range(1) == 0) ? MAX_CHARS_RESET :
                              CNT_W'($urandom());
      endcase
      upper = 8'($urandom_range(255));
      set_regs($urandom_range(3) != 0, size_word,
               $urandom_range(3) != 0, {upper, limit_word});

      n_str = $urandom_range(5, 20);
      for (int s = 0; s < n_str; s++) begin
        eff = (limit_mirror == '0) ? 1 : int'(limit_mirror);
        case ($urandom_range(9))
          0:       len = 0;
          1, 2:    len = (eff <= 20) ? eff + $urandom_range(0, 3) : $urandom_range(1, 12);
          default: len = $urandom_range(1, 12);
        endcase
        send_random_string(len);
        // Now and then the sender holds off until every result is back.
        if ($urandom_range(99) < 4) begin
          ch_valid <= 1'b0;
          do @(negedge clk); while (n_pending != 0);
        end
      end
    end

    // Drain and verdict.
    calm = 1'b0;
    wait_quiet();
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
